FILE: design/fixed_string_line_filter_assert.svh
// assertion macros for the fixed string line filter
`ifndef FIXED_STRING_LINE_FILTER_ASSERT_SVH
`define FIXED_STRING_LINE_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define FSLF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fslf assertion failed");
`define FSLF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fslf assertion failed");
`else
`define FSLF_ASSERT_NOW(label, ante, cons)
`define FSLF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: design/fslf_pkg.sv
// shared types, constants and helpers of the fixed string line filter
package fslf_pkg;

  localparam int PATTERN_MAX_DEFAULT = 16;
  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  localparam logic KIND_LINE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_NUL      = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2,
    REG_QUIET          = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] index;
    logic [31:0] offset;
    logic [31:0] nbytes;
    status_t     status;
    logic        final_res;
  } rec_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // pattern byte idx, bytes 0..7 in the low word
  function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [3:0] idx);
    logic [63:0] w;
    w = idx[3] ? hi : lo;
    pat_byte = w[{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage

FILE: design/fixed_string_line_filter.sv
// fixed string line filter: the results of each accepted input word are registered into a result queue
// sustains one input word per cycle unless stalled; an end word with a pending matching line gives two
// results outside quiet mode, drained through a four-entry result queue that sets the input stall
// rst (synchronous) clears line counters, match flags, queue and registers to zero,
// with the line number at one
`include "fixed_string_line_filter_assert.svh"
module fixed_string_line_filter
  import fslf_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // apb
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        is_last,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic        record_kind,
  output logic [31:0] line_index,
  output logic [31:0] line_offset,
  output logic [31:0] line_bytes,
  output logic [1:0]  status,
  output logic        final_res
);

  localparam int FW = $clog2(PATTERN_MAX + 1);
  localparam logic [4:0] MAX_LEN = 5'(PATTERN_MAX);
  localparam logic [FW-1:0] FILL_MAX = FW'(PATTERN_MAX);
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  // configuration
  logic [63:0] pattern_low;
  logic [63:0] pattern_high;
  logic [4:0]  pattern_length;
  logic        quiet;

  // stream state
  logic [7:0]    match_window [PATTERN_MAX];
  logic [FW-1:0] window_fill;
  logic [31:0]   current_line;
  logic [31:0]   current_line_start;
  logic [31:0]   byte_position;
  logic          line_has_match;
  logic          any_line_matched;
  logic          nul_seen;

  // result queue
  rec_t          fifo [FIFO_DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [CW-1:0] count;

  logic in_acc, out_acc, cfg_wr;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_index_t'(paddr[4:3]))
      REG_PATTERN_LOW:    prdata = pattern_low;
      REG_PATTERN_HIGH:   prdata = pattern_high;
      REG_PATTERN_LENGTH: prdata = {59'd0, pattern_length};
      REG_QUIET:          prdata = {63'd0, quiet};
      default:            prdata = 64'd0;
    endcase
  end

  // per-word datapath
  logic [4:0]    eff_len;
  logic [7:0]    aligned [PATTERN_MAX];
  logic [7:0]    window_next [PATTERN_MAX];
  logic [FW-1:0] fill_next;
  logic [31:0]   line_next, start_next, pos_next, saved_pos;
  logic          lhm_next, amatch_next, nul_next, hit;
  logic          rec_line_vld;
  rec_t          rec_line, rec_stat;
  status_t       st;

  always_comb begin
    eff_len = (pattern_length > MAX_LEN) ? MAX_LEN : pattern_length;
    // pattern laid out against the window, newest byte at position zero
    for (int j = 0; j < PATTERN_MAX; j++) begin
      aligned[j] = pat_byte(pattern_low, pattern_high, 4'(eff_len - 5'd1 - 5'(j)));
    end

    window_next  = match_window;
    fill_next    = window_fill;
    line_next    = current_line;
    start_next   = current_line_start;
    pos_next     = byte_position;
    lhm_next     = line_has_match;
    amatch_next  = any_line_matched;
    nul_next     = nul_seen;
    rec_line_vld = 1'b0;
    rec_line     = '{kind: KIND_LINE, index: current_line, offset: current_line_start,
                     nbytes: 32'd0, status: ST_MATCH, final_res: 1'b0};
    saved_pos    = sat_inc(byte_position);
    hit          = 1'b0;

    if (has_byte && data_byte == CHAR_NEWLINE) begin
      rec_line_vld    = line_has_match && !quiet;
      rec_line.nbytes = saved_pos - 32'd1 - current_line_start;
      amatch_next     = any_line_matched || line_has_match;
      fill_next       = '0;
      lhm_next        = 1'b0;
      line_next       = sat_inc(current_line);
      start_next      = saved_pos;
      pos_next        = saved_pos;
    end else if (has_byte) begin
      if (data_byte == CHAR_NUL) nul_next = 1'b1;
      window_next[0] = data_byte;
      for (int j = 1; j < PATTERN_MAX; j++) window_next[j] = match_window[j-1];
      if (window_fill != FILL_MAX) fill_next = window_fill + FW'(1);
      pos_next = saved_pos;
      hit = (eff_len != 5'd0) && (5'(fill_next) >= eff_len);
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (5'(j) < eff_len && window_next[j] != aligned[j]) hit = 1'b0;
      end
      if (hit) lhm_next = 1'b1;
    end

    // end of content closes a pending unterminated line
    if (is_last && fill_next != '0) begin
      rec_line_vld    = lhm_next && !quiet;
      rec_line.index  = line_next;
      rec_line.offset = start_next;
      rec_line.nbytes = pos_next - start_next;
      amatch_next     = amatch_next || lhm_next;
    end

    if (eff_len == 5'd0)  st = ST_EMPTY;
    else if (nul_next)    st = ST_NUL;
    else if (amatch_next) st = ST_MATCH;
    else                  st = ST_NO_MATCH;
    rec_stat = '{kind: KIND_STATUS, index: 32'd0, offset: 32'd0, nbytes: 32'd0,
                 status: st, final_res: 1'b1};
  end

  // queue writes
  logic [1:0] n_push;
  rec_t       slot0, slot1;
  always_comb begin
    slot0  = rec_stat;
    slot1  = rec_stat;
    n_push = 2'd0;
    if (in_acc) begin
      if (rec_line_vld) begin
        slot0  = rec_line;
        n_push = is_last ? 2'd2 : 2'd1;
      end else if (is_last) begin
        n_push = 2'd1;
      end
    end
  end

  assign in_stall  = (count > CW'(FIFO_DEPTH - 2));
  assign out_valid = (count != '0);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) fifo[wr_ptr] <= slot0;
    if (n_push == 2'd2) fifo[wr_ptr + PW'(1)] <= slot1;
    if (in_acc) match_window <= window_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low        <= 64'd0;
      pattern_high       <= 64'd0;
      pattern_length     <= 5'd0;
      quiet              <= 1'b0;
      window_fill        <= '0;
      current_line       <= 32'd1;
      current_line_start <= 32'd0;
      byte_position      <= 32'd0;
      line_has_match     <= 1'b0;
      any_line_matched   <= 1'b0;
      nul_seen           <= 1'b0;
      rd_ptr             <= '0;
      wr_ptr             <= '0;
      count              <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_index_t'(paddr[4:3]))
          REG_PATTERN_LOW:    pattern_low    <= pwdata;
          REG_PATTERN_HIGH:   pattern_high   <= pwdata;
          REG_PATTERN_LENGTH: pattern_length <= pwdata[4:0];
          REG_QUIET:          quiet          <= pwdata[0];
          default:            ;
        endcase
      end
      if (in_acc) begin
        if (is_last) begin
          window_fill        <= '0;
          current_line       <= 32'd1;
          current_line_start <= 32'd0;
          byte_position      <= 32'd0;
          line_has_match     <= 1'b0;
          any_line_matched   <= 1'b0;
          nul_seen           <= 1'b0;
        end else begin
          window_fill        <= fill_next;
          current_line       <= line_next;
          current_line_start <= start_next;
          byte_position      <= pos_next;
          line_has_match     <= lhm_next;
          any_line_matched   <= amatch_next;
          nul_seen           <= nul_next;
        end
      end
      wr_ptr <= wr_ptr + PW'(n_push);
      if (out_acc) rd_ptr <= rd_ptr + PW'(1);
      count <= count + CW'(n_push) - CW'(out_acc);
    end
  end

  assign record_kind = fifo[rd_ptr].kind;
  assign line_index  = fifo[rd_ptr].index;
  assign line_offset = fifo[rd_ptr].offset;
  assign line_bytes  = fifo[rd_ptr].nbytes;
  assign status      = fifo[rd_ptr].status;
  assign final_res   = fifo[rd_ptr].final_res;

  `FSLF_ASSERT_NOW(a_queue_bound, 1'b1, count <= CW'(FIFO_DEPTH))
  `FSLF_ASSERT_NOW(a_fill_bound, 1'b1, window_fill <= FILL_MAX)
  `FSLF_ASSERT_NEXT(a_end_gives_status, in_acc && is_last, count != '0)
  `FSLF_ASSERT_NEXT(a_end_clears_stream, in_acc && is_last,
                    window_fill == '0 && current_line == 32'd1 && byte_position == 32'd0)

endmodule

FILE: tb/line_filter_checker.sv
// scoreboard for the fixed string line filter: predicts line and status records and checks them
`timescale 1ns / 1ps
module line_filter_checker
  import fslf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        is_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        record_kind,
  input  logic [31:0] line_index,
  input  logic [31:0] line_offset,
  input  logic [31:0] line_bytes,
  input  logic [1:0]  status,
  input  logic        final_res,
  output int          fail_count,
  output int          pending
);

  localparam int WIN = PATTERN_MAX_DEFAULT;

  // shadow copy of the registers
  logic [63:0] pat_lo, pat_hi;
  logic [4:0]  pat_len;
  logic        quiet_mode;

  // line matcher state
  logic [7:0]  window [WIN];
  logic [4:0]  fill;
  logic [31:0] line_no, line_start, pos;
  logic        line_hit, any_hit, nul_flag;

  rec_t expected_records [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [31:0] count_up(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [7:0] wanted_byte(input int i);
    return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
  endfunction

  function automatic int active_len();
    return (pat_len > WIN) ? WIN : int'(pat_len);
  endfunction

  task automatic restart_stream();
    for (int k = 0; k < WIN; k++) window[k] = 8'h00;
    fill = '0;
    line_no = 32'd1;
    line_start = '0;
    pos = '0;
    line_hit = 1'b0;
    any_hit = 1'b0;
    nul_flag = 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
    case (reg_index_t'(idx))
      REG_PATTERN_LOW:    pat_lo = v;
      REG_PATTERN_HIGH:   pat_hi = v;
      REG_PATTERN_LENGTH: pat_len = v[4:0];
      REG_QUIET:          quiet_mode = v[0];
      default: ;
    endcase
  endtask

  // close the current line, record it if it held the pattern
  task automatic finish_line(input logic [31:0] nbytes);
    rec_t r;
    if (line_hit) begin
      any_hit = 1'b1;
      if (!quiet_mode) begin
        r.kind = KIND_LINE;
        r.index = line_no;
        r.offset = line_start;
        r.nbytes = nbytes;
        r.status = ST_MATCH;
        r.final_res = 1'b0;
        expected_records.push_back(r);
      end
    end
    for (int k = 0; k < WIN; k++) window[k] = 8'h00;
    fill = '0;
    line_hit = 1'b0;
    line_no = count_up(line_no);
    line_start = pos;
  endtask

  task automatic shift_in(input logic [7:0] b);
    int n;
    logic hit;
    n = active_len();
    if (b == CHAR_NUL) nul_flag = 1'b1;
    for (int k = WIN - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = b;
    if (fill < WIN) fill = fill + 5'd1;
    pos = count_up(pos);
    if (n != 0 && fill >= n) begin
      hit = 1'b1;
      // newest byte sits at window[0], so the pattern reads backwards
      for (int i = 0; i < n; i++)
        if (window[n-1-i] != wanted_byte(i)) hit = 1'b0;
      if (hit) line_hit = 1'b1;
    end
  endtask

  task automatic predict_word(input logic [7:0] b, input logic has, input logic last);
    logic [31:0] next_pos;
    logic [31:0] nbytes;
    rec_t r;
    if (has) begin
      if (b == CHAR_NEWLINE) begin
        next_pos = count_up(pos);
        // length leaves the newline out
        nbytes = (next_pos - 32'd1) - line_start;
        pos = next_pos;
        finish_line(nbytes);
      end else begin
        shift_in(b);
      end
    end
    if (last) begin
      if (fill != 0) finish_line(pos - line_start);
      r.kind = KIND_STATUS;
      r.index = '0;
      r.offset = '0;
      r.nbytes = '0;
      if (active_len() == 0) r.status = ST_EMPTY;
      else if (nul_flag) r.status = ST_NUL;
      else if (any_hit) r.status = ST_MATCH;
      else r.status = ST_NO_MATCH;
      r.final_res = 1'b1;
      expected_records.push_back(r);
      restart_stream();
    end
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_record();
    rec_t want;
    if (expected_records.size() == 0) begin
      $error("record with nothing expected: kind %0d line %0d status %0d",
             record_kind, line_index, status);
      fail_count++;
    end else begin
      want = expected_records.pop_front();
      cmp_field("record_kind", 32'(want.kind), 32'(record_kind));
      cmp_field("line_index", want.index, line_index);
      cmp_field("line_offset", want.offset, line_offset);
      cmp_field("line_bytes", want.nbytes, line_bytes);
      cmp_field("status", 32'(want.status), 32'(status));
      cmp_field("final_res", 32'(want.final_res), 32'(final_res));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pat_lo = '0;
      pat_hi = '0;
      pat_len = '0;
      quiet_mode = 1'b0;
      restart_stream();
      expected_records.delete();
    end else begin
      if (psel && penable && pwrite && pready) write_reg(paddr[4:3], pwdata);
      if (in_valid && !in_stall) predict_word(data_byte, has_byte, is_last);
      if (out_valid && !out_stall) check_record();
    end
    pending <= expected_records.size();
  end

endmodule

FILE: tb/tb.sv
// testbench top for the fixed string line filter: clock, reset, register writes and byte streams
`timescale 1ns / 1ps
module tb
  import fslf_pkg::*;
;

  localparam int TARGET_WORDS = 1850;
  localparam int CALM_AFTER = 1550;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [7:0] b;
    logic       has;
    logic       last;
  } in_word_t;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_stall;
  logic [7:0]  data_byte;
  logic        has_byte, is_last;
  logic        out_valid, out_stall;
  logic        record_kind;
  logic [31:0] line_index, line_offset, line_bytes;
  logic [1:0]  status;
  logic        final_res;
  int          fail_count, pending;

  // stimulus-side copy of what was written, used to plant the pattern
  logic [63:0] cfg_lo, cfg_hi;
  logic [4:0]  cfg_len;
  bit          calm;
  int          words_sent;
  in_word_t    stream_words [$];

  fixed_string_line_filter dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .has_byte(has_byte), .is_last(is_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .record_kind(record_kind), .line_index(line_index), .line_offset(line_offset),
    .line_bytes(line_bytes), .status(status), .final_res(final_res)
  );

  line_filter_checker scoreboard (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .has_byte(has_byte), .is_last(is_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .record_kind(record_kind), .line_index(line_index), .line_offset(line_offset),
    .line_bytes(line_bytes), .status(status), .final_res(final_res),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // receiver: free stretches with stall bursts in between
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = $urandom_range(1, 24);
      repeat (n) @(negedge clk) out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 1) == 1) begin
        n = $urandom_range(1, 8);
        repeat (n) @(negedge clk) out_stall <= 1'b1;
      end
    end
  end

  function automatic in_word_t mk(input logic [7:0] b, input logic has, input logic last);
    in_word_t w;
    w.b = b;
    w.has = has;
    w.last = last;
    return w;
  endfunction

  function automatic int stim_len();
    return (cfg_len > 16) ? 16 : int'(cfg_len);
  endfunction

  function automatic logic [7:0] pat_at(input int i);
    return (i < 8) ? cfg_lo[8*i +: 8] : cfg_hi[8*(i-8) +: 8];
  endfunction

  function automatic logic [7:0] content_byte(input bit nul_mode);
    int unsigned sel;
    logic [7:0] b;
    sel = $urandom_range(0, 15);
    if (nul_mode && sel == 0) b = CHAR_NUL;
    else if (sel < 8 && stim_len() != 0) b = pat_at($urandom_range(0, stim_len() - 1));
    else if (sel < 12) b = 8'($urandom_range(0, 255));
    else b = 8'h61 + 8'($urandom_range(0, 3));
    if (b == CHAR_NEWLINE) b = 8'h7A;
    return b;
  endfunction

  task automatic send_word(input logic [7:0] b, input logic has, input logic last);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 8);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    has_byte <= has;
    is_last <= last;
    do @(posedge clk); while (in_stall);
    if (has || last) words_sent++;
  endtask

  // wait for every record, then let the result queue run dry
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [63:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] len, input logic q);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, {59'd0, len});
    write_reg(REG_QUIET, {63'd0, q});
    cfg_lo = lo;
    cfg_hi = hi;
    cfg_len = len;
  endtask

  task automatic pick_config();
    logic [63:0] lo, hi;
    logic [4:0] len;
    int unsigned pick;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    pick = $urandom_range(0, 11);
    if (pick == 0) begin
      lo = '0;
      hi = '0;
    end else if (pick == 1) begin
      lo = '1;
      hi = '1;
    end else if (pick != 2) begin
      // a newline in the pattern can never match, keep that rare
      for (int k = 0; k < 8; k++) begin
        if (lo[8*k +: 8] == CHAR_NEWLINE) lo[8*k +: 8] = 8'h41;
        if (hi[8*k +: 8] == CHAR_NEWLINE) hi[8*k +: 8] = 8'h42;
      end
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) len = 5'd0;
    else if (pick == 1) len = 5'd16;
    else if (pick == 2) len = 5'($urandom_range(17, 31));
    else len = 5'($urandom_range(1, 6));
    set_config(lo, hi, len, $urandom_range(0, 3) == 0);
  endtask

  task automatic build_stream();
    int nlines, pre, post, plen;
    bit nul_mode;
    logic [7:0] text [$];
    in_word_t w;
    stream_words.delete();
    nlines = $urandom_range(1, 5);
    nul_mode = ($urandom_range(0, 9) == 0);
    plen = stim_len();
    for (int l = 0; l < nlines; l++) begin
      text.delete();
      if ($urandom_range(0, 4) != 0) begin
        pre = $urandom_range(0, 5);
        post = $urandom_range(0, 5);
        repeat (pre) text.push_back(content_byte(nul_mode));
        if (plen != 0 && $urandom_range(0, 1) == 1)
          for (int i = 0; i < plen; i++) text.push_back(pat_at(i));
        repeat (post) text.push_back(content_byte(nul_mode));
      end
      foreach (text[i]) begin
        stream_words.push_back(mk(text[i], 1'b1, 1'b0));
        if ($urandom_range(0, 15) == 0)
          stream_words.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      end
      if (l < nlines - 1) begin
        stream_words.push_back(mk(CHAR_NEWLINE, 1'b1, 1'b0));
      end else begin
        case ($urandom_range(0, 3))
          0: stream_words.push_back(mk(CHAR_NEWLINE, 1'b1, 1'b1));
          1: begin
            stream_words.push_back(mk(CHAR_NEWLINE, 1'b1, 1'b0));
            stream_words.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
          end
          2: begin
            // end flag rides on the final word
            if (stream_words.size() != 0) begin
              w = stream_words.pop_back();
              w.last = 1'b1;
              stream_words.push_back(w);
            end else begin
              stream_words.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
            end
          end
          default: stream_words.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
        endcase
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    data_byte = '0;
    has_byte = 1'b0;
    is_last = 1'b0;
    cfg_lo = '0;
    cfg_hi = '0;
    cfg_len = '0;
    calm = 1'b0;
    words_sent = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // registers at reset: empty pattern status only
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(CHAR_NEWLINE, 1'b1, 1'b0);
    send_word(8'hA5, 1'b0, 1'b1);
    settle();
    set_config(64'h6261, 64'h0, 5'd2, 1'b0);
    // hit mid-line, ignored word, empty line, hit on an unterminated last line
    send_word(8'h78, 1'b1, 1'b0);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h79, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(CHAR_NEWLINE, 1'b1, 1'b0);
    send_word(CHAR_NEWLINE, 1'b1, 1'b0);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b1);
    // nul byte still gives the line record, status reports the nul
    send_word(CHAR_NUL, 1'b1, 1'b0);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(CHAR_NEWLINE, 1'b1, 1'b1);
    // no match anywhere
    send_word(8'h63, 1'b1, 1'b1);
    settle();
    // quiet: status only
    set_config(64'h6261, 64'h0, 5'd2, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);

    while (words_sent < TARGET_WORDS) begin
      if (words_sent >= CALM_AFTER) calm = 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        settle();
        pick_config();
      end
      build_stream();
      foreach (stream_words[k])
        send_word(stream_words[k].b, stream_words[k].has, stream_words[k].last);
    end
    calm = 1'b1;
    settle();

    if (fail_count + pending == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/fslf_pkg.sv
design/fixed_string_line_filter.sv
tb/line_filter_checker.sv
tb/tb.sv
